@@ hw/rtl/lbpc_pkg.sv @@
// Shared types, codes and constants for the LED blink pattern controller.
package lbpc_pkg;

  localparam int DEFAULT_NUM_LEDS  = 4;
  localparam int DEFAULT_TIME_BITS = 16;

  // Fixed field widths of the command and result transactions.
  localparam int IDX_W      = 4;
  localparam int MS_W       = 16;
  localparam int REPEAT_W   = 16;
  localparam int MASK_W     = 4;
  localparam int COUNT_W    = 3;
  localparam int ACTIVE_W   = 5;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  localparam logic [MS_W-1:0]     MIN_ON_TICKS   = 16'd1;
  localparam logic [MS_W-1:0]     MIN_OFF_TICKS  = 16'd1;
  localparam logic [REPEAT_W-1:0] REPEAT_FOREVER = 16'hFFFF;

  localparam logic [COUNT_W-1:0] ENABLED_COUNT_RESET = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_ENABLED_COUNT = 1'b0;
  localparam logic CFG_NOTIFY_MASK   = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_BLINK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_BUSY    = 2'd2
  } status_t;

  // Per-LED control decoded from one command.
  typedef struct packed {
    logic commit;
    logic tick;
    logic steady_on;
    logic steady_off;
    logic blink;
    logic notify;
  } led_ctl_t;

endpackage

@@ hw/rtl/lbpc_led_unit.sv @@
// Per-LED state and next-state logic: level, phase timer, repeats and busy flag.
module lbpc_led_unit #(
  parameter int TIME_BITS = lbpc_pkg::DEFAULT_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbpc_pkg::led_ctl_t            ctl,
  input  logic [TIME_BITS-1:0]          on_len,
  input  logic [TIME_BITS-1:0]          off_len,
  input  logic [lbpc_pkg::REPEAT_W-1:0] repeat_total,
  output logic                          level,
  output logic                          level_nxt,
  output logic                          busy_nxt,
  output logic                          done
);

  logic                          level_r;
  logic                          running_r, running_nxt;
  logic                          busy_r;
  logic [TIME_BITS-1:0]          remaining_r, remaining_nxt;
  logic [lbpc_pkg::REPEAT_W-1:0] repeats_r, repeats_nxt;
  logic [TIME_BITS-1:0]          on_len_r, on_len_nxt;
  logic [TIME_BITS-1:0]          off_len_r, off_len_nxt;

  always_comb begin
    level_nxt     = level_r;
    running_nxt   = running_r;
    busy_nxt      = busy_r;
    remaining_nxt = remaining_r;
    repeats_nxt   = repeats_r;
    on_len_nxt    = on_len_r;
    off_len_nxt   = off_len_r;
    done          = 1'b0;
    if (ctl.tick) begin
      if (running_r) begin
        if (remaining_r > TIME_BITS'(1)) begin
          remaining_nxt = remaining_r - TIME_BITS'(1);
        end else if (repeats_r == '0) begin
          // Pattern finished: the LED goes dark and the timer stops.
          level_nxt     = 1'b0;
          running_nxt   = 1'b0;
          remaining_nxt = '0;
          repeats_nxt   = '0;
          if (ctl.notify) begin
            busy_nxt = 1'b0;
            done     = 1'b1;
          end
        end else if (level_r) begin
          level_nxt     = 1'b0;
          remaining_nxt = off_len_r;
        end else begin
          if (repeats_r != lbpc_pkg::REPEAT_FOREVER) begin
            repeats_nxt = repeats_r - lbpc_pkg::REPEAT_W'(1);
          end
          level_nxt     = 1'b1;
          remaining_nxt = on_len_r;
        end
      end
    end else if (ctl.steady_on || ctl.steady_off) begin
      level_nxt     = ctl.steady_on;
      running_nxt   = 1'b0;
      remaining_nxt = '0;
      repeats_nxt   = '0;
    end else if (ctl.blink) begin
      busy_nxt      = 1'b1;
      on_len_nxt    = on_len;
      off_len_nxt   = off_len;
      repeats_nxt   = repeat_total;
      level_nxt     = 1'b1;
      running_nxt   = 1'b1;
      remaining_nxt = on_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      running_r   <= 1'b0;
      busy_r      <= 1'b0;
      remaining_r <= '0;
      repeats_r   <= '0;
      on_len_r    <= '0;
      off_len_r   <= '0;
    end else if (ctl.commit) begin
      level_r     <= level_nxt;
      running_r   <= running_nxt;
      busy_r      <= busy_nxt;
      remaining_r <= remaining_nxt;
      repeats_r   <= repeats_nxt;
      on_len_r    <= on_len_nxt;
      off_len_r   <= off_len_nxt;
    end
  end

  assign level = level_r;

endmodule

@@ hw/rtl/led_blink_pattern_controller_core.sv @@
// Top level of the LED blink pattern controller: command register, LED units, result register.
//
// Usage: commands arrive on the in_ stream. in_tuser carries the command (tick, on, off,
// blink); in_tdata carries the LED index, on and off times, repeat count and force flag.
// Every command yields exactly one result transaction on the out_ stream with a status,
// the LED levels, the busy flags and the LEDs that completed on this tick.
// The cfg_ port sets the number of enabled LEDs and the per-LED completion notify mask;
// write it only while no command is in flight.
// A command passes through the command register and then the result register, which
// drives out_tvalid and out_tdata.
// Throughput: one command per cycle while out_tready stays high. All LED timers are
// updated in parallel by the single register-to-register step from the command
// register into the per-LED state.
// A stalled out_tready holds the result; one more command may then wait in the command
// register, after which in_tready drops until the result is taken.
// Reset (rst_n low at a clock edge) turns every LED off, stops all timers, clears the
// busy flags, empties both registers and restores the configuration defaults.
module led_blink_pattern_controller_core #(
  parameter int NUM_LEDS  = lbpc_pkg::DEFAULT_NUM_LEDS,
  parameter int TIME_BITS = lbpc_pkg::DEFAULT_TIME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [lbpc_pkg::MASK_W-1:0]     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,   // cmd
  // led_index[3:0], on_ms[19:4], off_ms[35:20], repeat_total[51:36], force_req[52]
  input  logic [lbpc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[1:0], led_levels[5:2], busy_mask[9:6], completed_mask[13:10]
  output logic [lbpc_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int EXT_W = (TIME_BITS > lbpc_pkg::MS_W) ? TIME_BITS : lbpc_pkg::MS_W;

  // Configuration registers.
  logic [lbpc_pkg::COUNT_W-1:0] en_count_r;
  logic [lbpc_pkg::MASK_W-1:0]  notify_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_count_r    <= lbpc_pkg::ENABLED_COUNT_RESET;
      notify_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lbpc_pkg::CFG_ENABLED_COUNT: en_count_r    <= cfg_wdata[lbpc_pkg::COUNT_W-1:0];
        lbpc_pkg::CFG_NOTIFY_MASK:   notify_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Command register.
  logic                          item_vld_r;
  lbpc_pkg::cmd_t                cmd_r;
  logic [lbpc_pkg::IDX_W-1:0]    idx_r;
  logic [lbpc_pkg::MS_W-1:0]     on_ms_r;
  logic [lbpc_pkg::MS_W-1:0]     off_ms_r;
  logic [lbpc_pkg::REPEAT_W-1:0] repeat_r;
  logic                          force_r;
  logic                          advance;
  logic                          in_fire;

  assign advance   = item_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !item_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_fire) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= lbpc_pkg::cmd_t'(in_tuser);
      idx_r    <= in_tdata[3:0];
      on_ms_r  <= in_tdata[19:4];
      off_ms_r <= in_tdata[35:20];
      repeat_r <= in_tdata[51:36];
      force_r  <= in_tdata[52];
    end
  end

  // Phase lengths: raised to the minimum and saturated to the timer width.
  logic [EXT_W-1:0]     on_ext, off_ext;
  logic [TIME_BITS-1:0] on_len, off_len;

  always_comb begin
    on_ext  = (on_ms_r < lbpc_pkg::MIN_ON_TICKS) ?
              EXT_W'(lbpc_pkg::MIN_ON_TICKS) : EXT_W'(on_ms_r);
    off_ext = (off_ms_r < lbpc_pkg::MIN_OFF_TICKS) ?
              EXT_W'(lbpc_pkg::MIN_OFF_TICKS) : EXT_W'(off_ms_r);
    if (on_ext > EXT_W'({TIME_BITS{1'b1}})) begin
      on_ext = EXT_W'({TIME_BITS{1'b1}});
    end
    if (off_ext > EXT_W'({TIME_BITS{1'b1}})) begin
      off_ext = EXT_W'({TIME_BITS{1'b1}});
    end
    on_len  = on_ext[TIME_BITS-1:0];
    off_len = off_ext[TIME_BITS-1:0];
  end

  // Command decode and status.
  logic [lbpc_pkg::ACTIVE_W-1:0] active;
  logic                          idx_valid;
  logic [NUM_LEDS-1:0]           sel;
  logic [NUM_LEDS-1:0]           level;
  logic [NUM_LEDS-1:0]           level_nxt;
  logic [NUM_LEDS-1:0]           busy_nxt;
  logic [NUM_LEDS-1:0]           done;
  logic                          target_level;
  lbpc_pkg::status_t             status;

  assign active = (lbpc_pkg::ACTIVE_W'(en_count_r) > lbpc_pkg::ACTIVE_W'(NUM_LEDS)) ?
                  lbpc_pkg::ACTIVE_W'(NUM_LEDS) : lbpc_pkg::ACTIVE_W'(en_count_r);
  assign idx_valid    = lbpc_pkg::ACTIVE_W'(idx_r) < active;
  assign target_level = |(level & sel);

  // The index is checked before the LED-on test of a blink.
  always_comb begin
    if (cmd_r == lbpc_pkg::CMD_TICK) begin
      status = lbpc_pkg::STATUS_OK;
    end else if (!idx_valid) begin
      status = lbpc_pkg::STATUS_INVALID;
    end else if (cmd_r == lbpc_pkg::CMD_BLINK && target_level && !force_r) begin
      status = lbpc_pkg::STATUS_BUSY;
    end else begin
      status = lbpc_pkg::STATUS_OK;
    end
  end

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    lbpc_pkg::led_ctl_t ctl;
    logic               notify;

    if (i < lbpc_pkg::MASK_W) begin : g_notify
      assign notify = notify_mask_r[i];
    end else begin : g_no_notify
      assign notify = 1'b0;
    end

    assign sel[i] = idx_valid && (idx_r == lbpc_pkg::IDX_W'(i));

    always_comb begin
      ctl.commit     = advance;
      ctl.tick       = (cmd_r == lbpc_pkg::CMD_TICK) &&
                       (lbpc_pkg::ACTIVE_W'(i) < active);
      ctl.steady_on  = sel[i] && (cmd_r == lbpc_pkg::CMD_ON);
      ctl.steady_off = sel[i] && (cmd_r == lbpc_pkg::CMD_OFF);
      ctl.blink      = sel[i] && (cmd_r == lbpc_pkg::CMD_BLINK) &&
                       (status == lbpc_pkg::STATUS_OK);
      ctl.notify     = notify;
    end

    lbpc_led_unit #(
      .TIME_BITS(TIME_BITS)
    ) u_led (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .on_len      (on_len),
      .off_len     (off_len),
      .repeat_total(repeat_r),
      .level       (level[i]),
      .level_nxt   (level_nxt[i]),
      .busy_nxt    (busy_nxt[i]),
      .done        (done[i])
    );
  end

  // Only the first four LEDs appear in the result masks.
  logic [lbpc_pkg::MASK_W-1:0] levels_m, busy_m, done_m;

  for (genvar g = 0; g < lbpc_pkg::MASK_W; g++) begin : g_mask
    if (g < NUM_LEDS) begin : g_used
      assign levels_m[g] = level_nxt[g];
      assign busy_m[g]   = busy_nxt[g];
      assign done_m[g]   = done[g];
    end else begin : g_unused
      assign levels_m[g] = 1'b0;
      assign busy_m[g]   = 1'b0;
      assign done_m[g]   = 1'b0;
    end
  end

  // Result register.
  logic                            out_vld_r;
  logic [lbpc_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, done_m, busy_m, levels_m, status};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // A command leaving the command register always lands in the result register.
  assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_tvalid)
    else $error("result register did not capture an advancing command");

  // An LED that reports completion has its busy flag cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[13:10] & out_tdata[9:6]) == '0))
    else $error("completed LED still flagged busy");

  // Completion is only reported for ticks.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r != lbpc_pkg::CMD_TICK) |=> (out_tdata[13:10] == '0))
    else $error("completion reported for a non-tick command");

endmodule

@@ verif/led_blink_checker.sv @@
// Checker for the LED blink pattern controller: predicts every result and compares it.
module led_blink_checker
  import lbpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [MASK_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [1:0]            in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen,
  output int                    completions_seen
);

  localparam int LEDS = DEFAULT_NUM_LEDS;

  typedef struct packed {
    status_t           status;
    logic [MASK_W-1:0] levels;
    logic [MASK_W-1:0] busy;
    logic [MASK_W-1:0] done;
  } led_result_t;

  logic [COUNT_W-1:0] enabled_count;
  logic [MASK_W-1:0]  notify_mask;
  logic               lit     [LEDS];
  logic               timing  [LEDS];
  logic               claimed [LEDS];
  logic [MS_W-1:0]    ticks_left  [LEDS];
  logic [REPEAT_W-1:0] cycles_left [LEDS];
  logic [MS_W-1:0]    on_len  [LEDS];
  logic [MS_W-1:0]    off_len [LEDS];

  led_result_t expected_results[$];

  function automatic logic [MS_W-1:0] clamp_phase(logic [MS_W-1:0] v, logic [MS_W-1:0] floor_v);
    return (v < floor_v) ? floor_v : v;
  endfunction

  // Applies one command to the LED model and returns the result it should produce.
  function automatic led_result_t apply_command(cmd_t cmd, logic [IN_DATA_W-1:0] d);
    led_result_t     r;
    int              active;
    logic [IDX_W-1:0] idx;
    r = '0;
    r.status = STATUS_OK;
    active = (enabled_count < LEDS) ? int'(enabled_count) : LEDS;
    idx = d[3:0];
    if (cmd == CMD_TICK) begin
      for (int i = 0; i < active; i++) begin
        if (timing[i]) begin
          if (ticks_left[i] > 1) begin
            ticks_left[i] = ticks_left[i] - MS_W'(1);
          end else begin
            ticks_left[i] = '0;
            if (cycles_left[i] == 0) begin
              // Pattern finished; busy only clears where notify is registered.
              lit[i] = 1'b0;
              timing[i] = 1'b0;
              if (notify_mask[i]) begin
                claimed[i] = 1'b0;
                r.done[i] = 1'b1;
              end
            end else if (lit[i]) begin
              lit[i] = 1'b0;
              ticks_left[i] = off_len[i];
            end else begin
              if (cycles_left[i] != REPEAT_FOREVER) begin
                cycles_left[i] = cycles_left[i] - REPEAT_W'(1);
              end
              lit[i] = 1'b1;
              ticks_left[i] = on_len[i];
            end
          end
        end
      end
    end else if (int'(idx) >= active) begin
      r.status = STATUS_INVALID;
    end else if (cmd == CMD_ON || cmd == CMD_OFF) begin
      lit[idx] = (cmd == CMD_ON);
      timing[idx] = 1'b0;
      ticks_left[idx] = '0;
      cycles_left[idx] = '0;
    end else if (lit[idx] && !d[52]) begin
      r.status = STATUS_BUSY;
    end else begin
      claimed[idx] = 1'b1;
      on_len[idx] = clamp_phase(d[19:4], MIN_ON_TICKS);
      off_len[idx] = clamp_phase(d[35:20], MIN_OFF_TICKS);
      cycles_left[idx] = d[51:36];
      lit[idx] = 1'b1;
      timing[idx] = 1'b1;
      ticks_left[idx] = on_len[idx];
    end
    for (int i = 0; i < LEDS; i++) begin
      r.levels[i] = lit[i];
      r.busy[i] = claimed[i];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : watch
    led_result_t want;
    if (!rst_n) begin
      enabled_count = ENABLED_COUNT_RESET;
      notify_mask = '0;
      for (int i = 0; i < LEDS; i++) begin
        lit[i] = 1'b0;
        timing[i] = 1'b0;
        claimed[i] = 1'b0;
        ticks_left[i] = '0;
        cycles_left[i] = '0;
        on_len[i] = '0;
        off_len[i] = '0;
      end
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLED_COUNT) enabled_count = cfg_wdata[COUNT_W-1:0];
        else notify_mask = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        results_seen = results_seen + 1;
        completions_seen = completions_seen + $countones(out_tdata[13:10]);
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected", out_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(out_tdata[1:0]), 16'(want.status));
          check_field("led_levels", 16'(out_tdata[5:2]), 16'(want.levels));
          check_field("busy_mask", 16'(out_tdata[9:6]), 16'(want.busy));
          check_field("completed_mask", 16'(out_tdata[13:10]), 16'(want.done));
          check_field("padding", 16'(out_tdata[15:14]), '0);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_command(cmd_t'(in_tuser), in_tdata));
      pending <= expected_results.size();
    end
  end

endmodule

@@ verif/tb_led_blink_pattern_controller_core.sv @@
// Testbench top for the LED blink pattern controller: stimulus, configuration and verdict.
module tb_led_blink_pattern_controller_core;
  import lbpc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_ENABLED_COUNT;
  logic [MASK_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic [1:0]            in_tuser = CMD_TICK;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int results_seen;
  int completions_seen;
  int cmd_count[4];
  int stall_left = 0;
  bit quiet = 1'b0;

  // Register settings per random phase; 4'hC checks that only the low three bits count.
  logic [3:0] phase_count[8] = '{4'd4, 4'd2, 4'd7, 4'd0, 4'hC, 4'd1, 4'd3, 4'd4};
  logic [3:0] phase_mask[8]  = '{4'h0, 4'h5, 4'hA, 4'hF, 4'h3, 4'h0, 4'h6, 4'hF};
  int         phase_len[8]   = '{252, 252, 252, 60, 252, 252, 252, 252};

  always #1 clk = ~clk;

  led_blink_pattern_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  led_blink_checker led_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tuser         (in_tuser),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen),
    .completions_seen (completions_seen)
  );

  // Result side backpressure in bursts of random length.
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_command(cmd_t c, logic [IDX_W-1:0] idx, logic [MS_W-1:0] on_t,
                              logic [MS_W-1:0] off_t, logic [REPEAT_W-1:0] rep, logic frc);
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {3'b000, frc, rep, off_t, on_t, idx};
    do @(posedge clk); while (!in_tready);
    cmd_count[c]++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Waits until every result is back, then writes both registers.
  task automatic drain_and_configure(logic [3:0] count_val, logic [3:0] mask_val);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENABLED_COUNT;
    cfg_wdata <= count_val;
    @(posedge clk);
    cfg_index <= CFG_NOTIFY_MASK;
    cfg_wdata <= mask_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short phases so that patterns run to completion, sometimes anything.
  function automatic logic [MS_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return MS_W'($urandom_range(0, 3));
    if (r < 9) return MS_W'($urandom_range(0, 20));
    return MS_W'($urandom);
  endfunction

  function automatic logic [REPEAT_W-1:0] pick_repeat();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return REPEAT_W'($urandom_range(0, 2));
    if (r < 13) return REPEAT_FOREVER;
    if (r < 17) return REPEAT_W'($urandom_range(0, 5));
    return REPEAT_W'($urandom);
  endfunction

  task automatic random_command();
    int   r;
    cmd_t c;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 55) c = CMD_TICK;
    else if (r < 65) c = CMD_ON;
    else if (r < 75) c = CMD_OFF;
    else c = CMD_BLINK;
    idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 15)) :
                                        IDX_W'($urandom_range(0, 3));
    send_command(c, idx, pick_time(), pick_time(), pick_repeat(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    #2_000_000;
    $display("tb_led_blink_pattern_controller_core failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    drain_and_configure(4'd4, 4'hF);

    // Directed part: clamping, refusal, invalid indexes, forever and maximal patterns.
    send_command(CMD_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_command(CMD_ON, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_BLINK, 4'd0, 16'd5, 16'd5, 16'd1, 1'b0);
    send_command(CMD_BLINK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_command(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_OFF, 4'd3, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_ON, 4'hF, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_BLINK, 4'd4, 16'd1, 16'd1, 16'd0, 1'b1);
    send_command(CMD_BLINK, 4'd1, 16'd2, 16'd1, 16'd1, 1'b0);
    repeat (6) send_command(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_BLINK, 4'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_command(CMD_BLINK, 4'd3, 16'd1, 16'd1, REPEAT_FOREVER, 1'b0);
    repeat (4) send_command(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_ON, 4'd2, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_OFF, 4'd3, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_OFF, 4'd2, 16'd0, 16'd0, 16'd0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      drain_and_configure(phase_count[p], phase_mask[p]);
      for (int k = 0; k < phase_len[p]; k++) begin
        // The last phase runs flat out; elsewhere some stretches have no idling.
        if (p == 7) quiet <= 1'b1;
        else if (k % 50 == 0) quiet <= ($urandom_range(0, 3) == 0);
        random_command();
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks, %0d on, %0d off and %0d blink commands %s",
             cmd_count[CMD_TICK], cmd_count[CMD_ON], cmd_count[CMD_OFF],
             cmd_count[CMD_BLINK], "over 9 register settings.");
    $display("Checked %0d results, %0d LED completions among them.",
             results_seen, completions_seen);
    if (mismatches == 0) begin
      $display("tb_led_blink_pattern_controller_core passed");
    end else begin
      $display("tb_led_blink_pattern_controller_core failed");
    end
    $finish;
  end

endmodule

@@ led_blink_pattern_controller_core.f @@
hw/rtl/lbpc_pkg.sv
hw/rtl/lbpc_led_unit.sv
hw/rtl/led_blink_pattern_controller_core.sv
verif/led_blink_checker.sv
verif/tb_led_blink_pattern_controller_core.sv
